[rtl/core/salc_pkg.sv]
`default_nettype none

package salc_pkg;

	// access commands
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_FETCH  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_SET_INDEX_BITS    = 2'd0;
	localparam logic [1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE       = 2'd2;

	// field widths
	localparam int CMD_W   = 2;
	localparam int ADDR_W  = 64;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 2;

	typedef logic [COUNT_W-1:0] count_t;

	// add one unless inc is low or the count is already at its top
	function automatic count_t sat_inc(input count_t v, input logic inc);
		count_t r;
		r = v;
		if (inc && (v != {COUNT_W{1'b1}})) begin
			r = v + count_t'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/set_assoc_lru_cache_model.sv]
`default_nettype none
// Tag store of a set-associative cache with least-recently-used replacement.
// Command channel: a transaction (command, address) is taken at a rising edge
// where start is high and busy is low. Fetch commands leave cache contents alone.
// Result channel: done is high for exactly one cycle with accessed, hit,
// evicted, extra_hit and the three saturating totals; the receiver cannot
// stall, so nothing waits on it.
// Timing: a fetch returns done in the cycle after it is taken and the block can
// take the next transaction in that same cycle. Any other command walks the
// ways in use one per cycle through a single tag compare and age compare
// unit fed by the registered tag and stamp memory reads, so done arrives
// once the scan has drained and the write-back is done; busy is high
// until then. A modify updates the line once, with its store half folded
// into the same write-back.
// Reset: after arst_n releases, the valid bits are cleared one set per cycle,
// all 2**MAX_SET_BITS sets, with busy high. Configuration writes (cfg_we,
// cfg_index, cfg_data) are taken on any edge, including during that pass.
module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8,
	parameter int STAMP_WIDTH  = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [salc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [salc_pkg::CFG_W-1:0]         cfg_data,
	input  wire                                start,
	output logic                               busy,
	input  wire  [salc_pkg::CMD_W-1:0]         command,
	input  wire  [salc_pkg::ADDR_W-1:0]        address,
	output logic                               done,
	output logic                               accessed,
	output logic                               hit,
	output logic                               evicted,
	output logic                               extra_hit,
	output logic [salc_pkg::COUNT_W-1:0]       hits_total,
	output logic [salc_pkg::COUNT_W-1:0]       misses_total,
	output logic [salc_pkg::COUNT_W-1:0]       evictions_total
);

	localparam int NUM_SETS  = 1 << MAX_SET_BITS;
	localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
	localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
	localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int ADDR_W    = salc_pkg::ADDR_W;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	// storage
	logic [MAX_WAYS-1:0]    valid_mem [NUM_SETS];
	logic [ADDR_W-1:0]      tag_mem   [NUM_LINES];
	logic [STAMP_WIDTH-1:0] stamp_mem [NUM_LINES];

	logic [1:0]             state_q;
	logic [SET_W-1:0]       clr_idx_q;
	logic [2:0]             set_bits_q;
	logic [5:0]             off_bits_q;
	logic [3:0]             ways_cfg_q;

	logic                   modify_q;
	logic [SET_W-1:0]       set_q;
	logic [ADDR_W-1:0]      tag_q;
	logic [WCNT_W-1:0]      issue_way_q;
	logic                   cmp_vld_s1;
	logic [WCNT_W-1:0]      cmp_way_s1;
	logic [MAX_WAYS-1:0]    valid_rd_q;
	logic [ADDR_W-1:0]      tag_rd_q;
	logic [STAMP_WIDTH-1:0] stamp_rd_q;

	logic                   hit_found_q;
	logic [WCNT_W-1:0]      hit_way_q;
	logic                   inv_found_q;
	logic [WCNT_W-1:0]      inv_way_q;
	logic [STAMP_WIDTH-1:0] best_age_q;
	logic [WCNT_W-1:0]      age_way_q;

	logic [STAMP_WIDTH-1:0] clock_q;
	salc_pkg::count_t       hit_cnt_q;
	salc_pkg::count_t       miss_cnt_q;
	salc_pkg::count_t       evict_cnt_q;

	logic                   done_q;
	logic                   accessed_q;
	logic                   hit_q;
	logic                   evicted_q;
	logic                   extra_hit_q;

	logic                   accept;
	logic [WCNT_W-1:0]      ways_eff;
	logic [2:0]             sbits;
	logic [6:0]             tshift;
	logic [ADDR_W-1:0]      set_mask;
	logic [ADDR_W-1:0]      set_full;
	logic [ADDR_W-1:0]      tag_new;
	logic [LINE_W-1:0]      rd_line;
	logic                   issue_more;
	logic                   cmp_valid;
	logic                   cmp_match;
	logic [STAMP_WIDTH-1:0] cmp_age;
	logic [WCNT_W-1:0]      pick_way;
	logic [LINE_W-1:0]      wr_line;
	logic                   upd_evict;
	logic [MAX_WAYS-1:0]    pick_onehot;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// effective configuration
	always_comb begin
		if (ways_cfg_q == 4'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (32'(ways_cfg_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_cfg_q);
		end
		if (32'(set_bits_q) > MAX_SET_BITS) begin
			sbits = 3'(MAX_SET_BITS);
		end else begin
			sbits = set_bits_q;
		end
	end

	// split the address into set and tag
	always_comb begin
		tshift   = 7'(sbits) + 7'(off_bits_q);
		set_mask = (ADDR_W'(1) << sbits) - ADDR_W'(1);
		set_full = (address >> off_bits_q) & set_mask;
		if (tshift >= 7'd64) begin
			tag_new = '0;
		end else begin
			tag_new = address >> tshift[5:0];
		end
	end

	// way scan: read address and compare unit
	always_comb begin
		issue_more = (issue_way_q < ways_eff);
		rd_line    = LINE_W'(32'(set_q) * MAX_WAYS + 32'(issue_way_q[WAY_W-1:0]));
		cmp_valid  = valid_rd_q[cmp_way_s1[WAY_W-1:0]];
		cmp_match  = cmp_valid && (tag_rd_q == tag_q);
		cmp_age    = clock_q - stamp_rd_q;
	end

	// replacement choice for the write-back
	always_comb begin
		upd_evict = !hit_found_q && !inv_found_q;
		if (hit_found_q) begin
			pick_way = hit_way_q;
		end else if (inv_found_q) begin
			pick_way = inv_way_q;
		end else begin
			pick_way = age_way_q;
		end
		wr_line     = LINE_W'(32'(set_q) * MAX_WAYS + 32'(pick_way[WAY_W-1:0]));
		pick_onehot = '0;
		pick_onehot[pick_way[WAY_W-1:0]] = 1'b1;
	end

	// memory read ports, registered
	always_ff @(posedge clk) begin
		valid_rd_q <= valid_mem[set_q];
		tag_rd_q   <= tag_mem[rd_line];
		stamp_rd_q <= stamp_mem[rd_line];
	end

	// memory write ports: clearing pass and line update
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			valid_mem[clr_idx_q] <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (!hit_found_q) begin
				valid_mem[set_q] <= valid_rd_q | pick_onehot;
				tag_mem[wr_line] <= tag_q;
			end
			if (modify_q) begin
				stamp_mem[wr_line] <= clock_q + STAMP_WIDTH'(1);
			end else begin
				stamp_mem[wr_line] <= clock_q;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd0;
			off_bits_q <= 6'd0;
			ways_cfg_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				salc_pkg::REG_SET_INDEX_BITS:    set_bits_q <= cfg_data[2:0];
				salc_pkg::REG_BLOCK_OFFSET_BITS: off_bits_q <= cfg_data[5:0];
				salc_pkg::REG_WAYS_IN_USE:       ways_cfg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer, counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			issue_way_q <= '0;
			cmp_vld_s1  <= 1'b0;
			clock_q     <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			// strobe a fetch at once, any other command after its write-back
			done_q <= (accept && (command == salc_pkg::CMD_FETCH)) ||
				(state_q == ST_UPDATE);
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SET_W'(1);
					if (clr_idx_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						issue_way_q <= '0;
						cmp_vld_s1  <= 1'b0;
						if (command != salc_pkg::CMD_FETCH) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue_more;
					if (issue_more) begin
						issue_way_q <= issue_way_q + WCNT_W'(1);
					end else if (!cmp_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					hit_cnt_q   <= salc_pkg::sat_inc(salc_pkg::sat_inc(hit_cnt_q, hit_found_q),
						modify_q);
					miss_cnt_q  <= salc_pkg::sat_inc(miss_cnt_q, !hit_found_q);
					evict_cnt_q <= salc_pkg::sat_inc(evict_cnt_q, upd_evict);
					if (modify_q) begin
						clock_q <= clock_q + STAMP_WIDTH'(2);
					end else begin
						clock_q <= clock_q + STAMP_WIDTH'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction payload and scan results
	always_ff @(posedge clk) begin
		if (accept) begin
			modify_q    <= (command == salc_pkg::CMD_MODIFY);
			set_q       <= SET_W'(set_full);
			tag_q       <= tag_new;
			hit_found_q <= 1'b0;
			inv_found_q <= 1'b0;
			accessed_q  <= 1'b0;
			hit_q       <= 1'b0;
			evicted_q   <= 1'b0;
			extra_hit_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && cmp_vld_s1) begin
			if (cmp_match && !hit_found_q) begin
				hit_found_q <= 1'b1;
				hit_way_q   <= cmp_way_s1;
			end
			if (!cmp_valid && !inv_found_q) begin
				inv_found_q <= 1'b1;
				inv_way_q   <= cmp_way_s1;
			end
			if ((cmp_way_s1 == '0) || (cmp_age > best_age_q)) begin
				best_age_q <= cmp_age;
				age_way_q  <= cmp_way_s1;
			end
		end
		if (state_q == ST_SCAN) begin
			cmp_way_s1 <= issue_way_q;
		end
		if (state_q == ST_UPDATE) begin
			accessed_q  <= 1'b1;
			hit_q       <= hit_found_q;
			evicted_q   <= upd_evict;
			extra_hit_q <= modify_q;
		end
	end

	assign done            = done_q;
	assign accessed        = accessed_q;
	assign hit             = hit_q;
	assign evicted         = evicted_q;
	assign extra_hit       = extra_hit_q;
	assign hits_total      = hit_cnt_q;
	assign misses_total    = miss_cnt_q;
	assign evictions_total = evict_cnt_q;

endmodule

`default_nettype wire
